@@ rtl/ultrasonic_echo_ranger_assert.svh @@
// Assertion helpers, clocked on the rising edge, masked while reset is low.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ranger check failed");

// Consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ranger check failed");

`endif

@@ rtl/uer_pkg.sv @@
package uer_pkg;

  localparam int TRIG_US_W  = 10;
  localparam int TIMEOUT_W  = 24;
  localparam int USPC_W     = 8;
  localparam int DIST_W     = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [TRIG_US_W-1:0] TRIG_US_RST   = 10'd50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 24'd960000;
  localparam logic [USPC_W-1:0]    USPC_RST      = 8'd58;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_US    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM     = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_TRIG      = 5'b00010,
    PH_WAIT_LOW  = 5'b00100,
    PH_WAIT_HIGH = 5'b01000,
    PH_MEASURE   = 5'b10000
  } phase_e;

endpackage

@@ rtl/uer_in_if.sv @@
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

@@ rtl/uer_out_if.sv @@
interface uer_out_if;
  logic                      valid;
  logic                      ready;
  logic                      trig_level;
  logic                      done_res;
  logic [uer_pkg::DIST_W-1:0] distance_cm;
  logic                      busy_res;

  modport source (output valid, output trig_level, output done_res, output distance_cm,
                  output busy_res, input ready);
  modport sink   (input valid, input trig_level, input done_res, input distance_cm,
                  input busy_res, output ready);
endinterface

@@ rtl/ultrasonic_echo_ranger.sv @@
// Channel | Dir | Payload                                         | Transfer
// in_ch   | in  | start_req, echo_level                           | valid & ready
// out_ch  | out | trig_level, done_res, distance_cm, busy_res     | valid & ready
// cfg     | in  | cfg_idx_i, cfg_wdata_i                          | cfg_we_i
//
// Ticks: a tick that does not end a measurement leaves the input free for the next
//   tick. The tick that ends one starts a restoring divider, one quotient bit per
//   cycle, and no further tick is taken until the divider has finished.
// Reset: phase idle, count zero, registers at their defaults, output empty.
// Stalls: results sit in one output register; a new tick is taken while it drains.
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger #(
  parameter int TICKS_PER_US = 32,
  parameter int COUNT_WIDTH  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  uer_in_if.sink                          in_ch,
  uer_out_if.source                       out_ch,
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // widths following from the parameters
  localparam int TPU_W  = $clog2(TICKS_PER_US + 1);
  localparam int LEN_W  = uer_pkg::TRIG_US_W + TPU_W;
  localparam int DIV_W  = uer_pkg::USPC_W + TPU_W;
  localparam int CW_A   = (COUNT_WIDTH > uer_pkg::TIMEOUT_W) ? COUNT_WIDTH : uer_pkg::TIMEOUT_W;
  localparam int CMP_W  = (CW_A > LEN_W) ? CW_A : LEN_W;
  localparam int QX_W   = (COUNT_WIDTH > uer_pkg::DIST_W) ? COUNT_WIDTH : uer_pkg::DIST_W;
  localparam int CNT_W  = $clog2(COUNT_WIDTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // config registers
  logic [uer_pkg::TRIG_US_W-1:0] trigger_us_q;
  logic [uer_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [uer_pkg::USPC_W-1:0]    us_per_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_us_q <= uer_pkg::TRIG_US_RST;
      timeout_q    <= uer_pkg::TIMEOUT_RST;
      us_per_cm_q  <= uer_pkg::USPC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uer_pkg::CFG_TRIGGER_US:    trigger_us_q <= cfg_wdata_i[uer_pkg::TRIG_US_W-1:0];
        uer_pkg::CFG_TIMEOUT_TICKS: timeout_q    <= cfg_wdata_i[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::CFG_US_PER_CM:     us_per_cm_q  <= cfg_wdata_i[uer_pkg::USPC_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // tick sequencer state
  uer_pkg::phase_e           phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]    elapsed_q, elapsed_d;

  // divider state
  logic                      div_active_q;
  logic [CNT_W-1:0]          div_cnt_q;
  logic [DIV_W-1:0]          rem_q;
  logic [COUNT_WIDTH-1:0]    quo_q;
  logic [DIV_W-1:0]          divisor_q;

  // output register
  logic                      out_valid_q;
  logic                      out_trig_q;
  logic                      out_done_q;
  logic [uer_pkg::DIST_W-1:0] out_dist_q;
  logic                      out_busy_q;

  logic in_ready;
  logic in_fire;

  // Ticks are held off while dividing, and while a result waits untaken.
  assign in_ready    = !div_active_q && (!out_valid_q || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Counter and limit compares, the threshold compares all at one common width.
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_W-1:0]       elapsed_x, inc_x, timeout_x, trig_len;
  logic                   limit_hit, meas_limit, trig_over;

  assign count_inc  = (elapsed_q == COUNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign elapsed_x  = CMP_W'(elapsed_q);
  assign inc_x      = CMP_W'(count_inc);
  assign timeout_x  = CMP_W'(timeout_q);
  assign trig_len   = CMP_W'(trigger_us_q) * CMP_W'(TICKS_PER_US);
  assign limit_hit  = (elapsed_x >= timeout_x) || (elapsed_q == COUNT_MAX);
  assign meas_limit = (inc_x >= timeout_x) || (count_inc == COUNT_MAX);
  assign trig_over  = (elapsed_x >= trig_len) || (elapsed_q == COUNT_MAX);

  logic r_trig, r_done, r_busy, meas_end;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    r_trig    = 1'b0;
    r_done    = 1'b0;
    meas_end  = 1'b0;
    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (in_ch.start_req) begin
          phase_d   = uer_pkg::PH_TRIG;
          elapsed_d = COUNT_WIDTH'(1);
          r_trig    = 1'b1;
        end
      end
      uer_pkg::PH_TRIG: begin
        if (trig_over) begin
          phase_d   = uer_pkg::PH_WAIT_LOW;
          elapsed_d = '0;
        end else begin
          r_trig    = 1'b1;
          elapsed_d = count_inc;
        end
      end
      // echo may still be high from a previous ping: wait for it to drop
      uer_pkg::PH_WAIT_LOW: begin
        if (!in_ch.echo_level || limit_hit) begin
          phase_d   = uer_pkg::PH_WAIT_HIGH;
          elapsed_d = '0;
        end else begin
          elapsed_d = count_inc;
        end
      end
      uer_pkg::PH_WAIT_HIGH: begin
        if (in_ch.echo_level || limit_hit) begin
          phase_d   = uer_pkg::PH_MEASURE;
          elapsed_d = '0;
        end else begin
          elapsed_d = count_inc;
        end
      end
      // count first, then test: the measured pulse includes this tick
      uer_pkg::PH_MEASURE: begin
        elapsed_d = count_inc;
        if (!in_ch.echo_level || meas_limit) begin
          meas_end  = 1'b1;
          r_done    = 1'b1;
          phase_d   = uer_pkg::PH_IDLE;
          elapsed_d = '0;
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
      end
    endcase
    r_busy = (phase_d != uer_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= uer_pkg::PH_IDLE;
      elapsed_q <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Divisor folds the tick scale in: floor(floor(n/a)/b) == floor(n/(a*b)).
  // A zero us_per_cm divides by one.
  logic [uer_pkg::USPC_W-1:0] us_eff;
  logic [DIV_W-1:0]           divisor_c;

  assign us_eff    = (us_per_cm_q == '0) ? uer_pkg::USPC_W'(1) : us_per_cm_q;
  assign divisor_c = DIV_W'(us_eff) * DIV_W'(TICKS_PER_US);

  // Restoring divider step: one quotient bit per cycle, shifted into quo_q.
  logic [DIV_W:0]         rem_sh, rem_sub;
  logic                   rem_ge;
  logic [DIV_W-1:0]       rem_next;
  logic [COUNT_WIDTH-1:0] quo_next;
  logic                   div_last;
  logic [QX_W-1:0]        quo_x;
  logic [uer_pkg::DIST_W-1:0] dist_sat;

  assign rem_sh   = {rem_q, quo_q[COUNT_WIDTH-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor_q};
  assign rem_ge   = (rem_sh >= {1'b0, divisor_q});
  assign rem_next = rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  assign quo_next = {quo_q[COUNT_WIDTH-2:0], rem_ge};
  assign div_last = div_active_q && (div_cnt_q == '0);

  assign quo_x    = QX_W'(quo_next);
  assign dist_sat = (quo_x > QX_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                        : quo_x[uer_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_active_q <= 1'b0;
      div_cnt_q    <= '0;
    end else if (in_fire && meas_end) begin
      div_active_q <= 1'b1;
      div_cnt_q    <= CNT_W'(COUNT_WIDTH - 1);
    end else if (div_active_q) begin
      div_active_q <= !div_last;
      div_cnt_q    <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && meas_end) begin
      rem_q     <= '0;
      quo_q     <= count_inc;
      divisor_q <= divisor_c;
    end else if (div_active_q) begin
      rem_q     <= rem_next;
      quo_q     <= quo_next;
    end
  end

  // Output register. A measurement-ending tick leaves it empty until the
  // divider has the distance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= !meas_end;
    end else if (div_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_trig_q <= r_trig;
      out_done_q <= r_done;
      out_dist_q <= '0;
      out_busy_q <= r_busy;
    end else if (div_last) begin
      out_trig_q <= 1'b0;
      out_done_q <= 1'b1;
      out_dist_q <= dist_sat;
      out_busy_q <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.trig_level  = out_trig_q;
  assign out_ch.done_res    = out_done_q;
  assign out_ch.distance_cm = out_dist_q;
  assign out_ch.busy_res    = out_busy_q;

  `UER_ASSERT_NOW(a_no_tick_while_div, clk_i, rst_ni, div_active_q, !in_ready)
  `UER_ASSERT_NOW(a_div_only_idle, clk_i, rst_ni, div_active_q, phase_q == uer_pkg::PH_IDLE)
  `UER_ASSERT_NEXT(a_meas_starts_div, clk_i, rst_ni, in_fire && meas_end, div_active_q)
  `UER_ASSERT_NEXT(a_div_gives_done, clk_i, rst_ni, div_last, out_valid_q && out_done_q)

endmodule

@@ test/tb_ultrasonic_echo_ranger.sv @@
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;

  localparam int          TICKS_PER_US = 32;
  localparam int          COUNT_WIDTH  = 24;
  localparam int unsigned COUNT_FULL   = (1 << COUNT_WIDTH) - 1;
  // One divider pass plus a margin, for the quiet spell before a register write
  // and at the end of the run.
  localparam int          SETTLE_CYCLES = COUNT_WIDTH + 8;
  // Far beyond the slowest correct run: every tick waiting out both idle draws
  // and every measurement its full divider pass.
  localparam int          CYCLE_LIMIT  = 4_000_000;
  localparam int          RANDOM_TICKS = 500;
  localparam int          RANDOM_PINGS = 4;

  typedef logic [uer_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // One result transfer, in port order.
  typedef struct packed {
    logic                       trig;
    logic                       done;
    logic [uer_pkg::DIST_W-1:0] dist_cm;
    logic                       busy;
  } ping_result_t;

  // Tracks the ranger tick by tick and holds the results still owed by the block.
  class ranger_scoreboard;
    int unsigned     trig_us   = uer_pkg::TRIG_US_RST;
    int unsigned     timeout   = uer_pkg::TIMEOUT_RST;
    int unsigned     divisor   = uer_pkg::USPC_RST;
    uer_pkg::phase_e phase     = uer_pkg::PH_IDLE;
    int unsigned     count     = 0;
    ping_result_t    pending[$];
    int              errors    = 0;
    int              dones     = 0;
    int              ping_ticks = 0;

    function void bump();
      if (count < COUNT_FULL) count++;
    endfunction

    function bit at_limit();
      return count >= timeout || count >= COUNT_FULL;
    endfunction

    // Advance one tick and queue the result it must produce.
    function void note_tick(logic start, logic echo);
      ping_result_t r;
      int unsigned  q;
      r = '0;
      if (phase != uer_pkg::PH_IDLE || start) ping_ticks++;
      case (phase)
        uer_pkg::PH_TRIG: begin
          if (count >= trig_us * TICKS_PER_US || count >= COUNT_FULL) begin
            phase = uer_pkg::PH_WAIT_LOW;
            count = 0;
          end else begin
            r.trig = 1'b1;
            bump();
          end
        end
        uer_pkg::PH_WAIT_LOW: begin
          if (!echo || at_limit()) begin
            phase = uer_pkg::PH_WAIT_HIGH;
            count = 0;
          end else begin
            bump();
          end
        end
        uer_pkg::PH_WAIT_HIGH: begin
          if (echo || at_limit()) begin
            phase = uer_pkg::PH_MEASURE;
            count = 0;
          end else begin
            bump();
          end
        end
        uer_pkg::PH_MEASURE: begin
          bump();
          if (!echo || at_limit()) begin
            q = (count / TICKS_PER_US) / ((divisor == 0) ? 1 : divisor);
            r.dist_cm = (q > uer_pkg::DIST_MAX) ? uer_pkg::DIST_MAX
                                                : q[uer_pkg::DIST_W-1:0];
            r.done = 1'b1;
            phase  = uer_pkg::PH_IDLE;
            count  = 0;
            dones++;
          end
        end
        default: begin
          phase = uer_pkg::PH_IDLE;
          if (start) begin
            phase  = uer_pkg::PH_TRIG;
            count  = 1;
            r.trig = 1'b1;
          end
        end
      endcase
      r.busy = (phase != uer_pkg::PH_IDLE);
      pending.push_back(r);
    endfunction

    function void check_result(ping_result_t got);
      ping_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none owed: trig=%b done=%b dist=%0d busy=%b",
                 $time, got.trig, got.done, got.dist_cm, got.busy);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch, expected trig=%b done=%b dist=%0d busy=%b,",
                 $time, want.trig, want.done, want.dist_cm, want.busy);
        $display("    got trig=%b done=%b dist=%0d busy=%b",
                 got.trig, got.done, got.dist_cm, got.busy);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             cycles;
  ranger_scoreboard               sb;

  uer_in_if  in_ch ();
  uer_out_if out_ch ();

  ultrasonic_echo_ranger u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ultrasonic_echo_ranger] ERROR");
      $finish;
    end
  end

  // Result side: a fresh stall draw per transfer, ready held high while it
  // waits so the stall lands on every phase of the block's work. Signals are
  // read straight after the edge, i.e. the values that the edge sampled.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result({out_ch.trig_level, out_ch.done_res, out_ch.distance_cm,
                       out_ch.busy_res});
    end
  end

  // One tick transfer. Valid is only lowered when a gap is drawn, so that a
  // back-to-back tick never sees valid dropped and raised in the same step.
  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_req  <= start;
    in_ch.echo_level <= echo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(start, echo);
  endtask

  // Stop offering ticks, let every owed result drain, then give the divider
  // time to finish so the block is idle for a register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A single register write.
  task automatic cfg_write(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= cfg_data_t'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // All three registers back to back; the write enable is lowered once.
  task automatic set_config(input int unsigned t_us, input int unsigned tmo,
                            input int unsigned divisor);
    cfg_we    <= 1'b1;
    cfg_idx   <= uer_pkg::CFG_TRIGGER_US;
    cfg_wdata <= cfg_data_t'(t_us);
    @(posedge clk);
    cfg_idx   <= uer_pkg::CFG_TIMEOUT_TICKS;
    cfg_wdata <= cfg_data_t'(tmo);
    @(posedge clk);
    cfg_idx   <= uer_pkg::CFG_US_PER_CM;
    cfg_wdata <= cfg_data_t'(divisor);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.trig_us = t_us & 32'h3FF;
    sb.timeout = tmo & 32'hFF_FFFF;
    sb.divisor = divisor & 32'hFF;
  endtask

  // A full ping from idle. The echo follows the phase that the scoreboard
  // tracks: high for hi_run ticks of the first wait, low for lo_run ticks of
  // the second, high for meas_run ticks of the measurement. A noisy ping flips
  // the echo now and then. Starts during the ping are random and must be ignored.
  task automatic ping(input int hi_run, input int lo_run, input int meas_run,
                      input bit noisy);
    int              remain;
    uer_pkg::phase_e seen;
    logic            echo;
    remain = 0;
    seen   = uer_pkg::PH_IDLE;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (sb.phase != uer_pkg::PH_IDLE) begin
      if (sb.phase != seen) begin
        seen = sb.phase;
        case (seen)
          uer_pkg::PH_WAIT_LOW:  remain = hi_run;
          uer_pkg::PH_WAIT_HIGH: remain = lo_run;
          uer_pkg::PH_MEASURE:   remain = meas_run;
          default:               remain = 0;
        endcase
      end
      case (seen)
        uer_pkg::PH_WAIT_LOW:  echo = (remain > 0);
        uer_pkg::PH_WAIT_HIGH: echo = (remain == 0);
        uer_pkg::PH_MEASURE:   echo = (remain > 0);
        default:               echo = 1'($urandom_range(0, 1));
      endcase
      if (noisy && $urandom_range(0, 9) == 0) echo = ~echo;
      if (remain > 0) remain--;
      send_tick(1'($urandom_range(0, 1)), echo);
    end
  endtask

  task automatic random_ping();
    int hi_run;
    int lo_run;
    int meas_run;
    int pick;
    hi_run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 12);
    lo_run = $urandom_range(0, 24);
    pick   = $urandom_range(0, 19);
    if (pick == 0)     meas_run = $urandom_range(0, 400);
    else if (pick < 6) meas_run = $urandom_range(0, 150);
    else               meas_run = $urandom_range(0, 40);
    ping(hi_run, lo_run, meas_run, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    int          tick_base;
    int          done_base;
    int unsigned t_us;
    int unsigned tmo;
    int unsigned divisor;
    sb = new;
    cycles           <= 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.start_req  <= 1'b0;
    in_ch.echo_level <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= uer_pkg::CFG_TRIGGER_US;
    cfg_wdata        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Idle ticks with no start: echo must be ignored, nothing goes busy.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    settle();

    // Timeout and divisor at their reset values; trigger shortened.
    cfg_write(uer_pkg::CFG_TRIGGER_US, 1);
    sb.trig_us = 1;
    ping(3, 5, 40, 1'b0);
    settle();

    // Zero trigger length, zero timeout, zero divisor: trigger for the start
    // tick only, every wait ends at once, measurement lasts one tick.
    set_config(0, 0, 0);
    ping(5, 5, 5, 1'b0);
    ping(0, 0, 0, 1'b0);
    settle();

    // Zero divisor on a real measurement, timeout at the counter's top value.
    set_config(1, COUNT_FULL, 0);
    ping(2, 3, 100, 1'b0);
    settle();

    // Short timeout that cuts every echo phase.
    set_config(4, 20, 255);
    ping(50, 50, 50, 1'b0);
    settle();

    // Small divisor: just over two centimetres' worth of echo.
    set_config(1, COUNT_FULL, 3);
    ping(0, 0, 3 * TICKS_PER_US * 2 + 5, 1'b0);
    settle();

    // Largest divisor on a short echo.
    set_config(1, COUNT_FULL, 255);
    ping(0, 0, 40, 1'b0);
    settle();

    // Echo already in place for every phase, plus a start hammered while busy.
    set_config(2, 100, 1);
    ping(0, 0, 0, 1'b0);
    ping(4, 4, 40, 1'b1);
    settle();

    // Random part: rounds of settings, each with a few pings and stray ticks.
    tick_base = sb.ping_ticks;
    done_base = sb.dones;
    while (sb.ping_ticks - tick_base < RANDOM_TICKS || sb.dones - done_base < RANDOM_PINGS) begin
      settle();
      t_us = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 2) : $urandom_range(0, 8);
      case ($urandom_range(0, 3))
        0:       tmo = $urandom_range(0, 8);
        1:       tmo = $urandom_range(10, 400);
        2:       tmo = $urandom_range(400, 3000);
        default: tmo = ($urandom_range(0, 1) != 0) ? COUNT_FULL : ($urandom & COUNT_FULL);
      endcase
      divisor = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 255);
      set_config(t_us, tmo, divisor);
      repeat ($urandom_range(1, 4)) begin
        random_ping();
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ultrasonic_echo_ranger] OK");
    end else begin
      $display("[ultrasonic_echo_ranger] ERROR");
    end
    $finish;
  end

endmodule
